>>> src/deq_pkg.sv
package deq_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 6;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_DELETE     = 3'd5,
        CMD_DUMP_ALL   = 3'd6,
        CMD_DUMP_FIRST = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_DUMP
    } state_t;

    typedef struct packed {
        cmd_t                       command;
        logic signed [VALUE_W-1:0]  operand;
    } deq_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  item_value;
        logic                       item_valid;
        logic                       last_of_run;
        status_t                    status;
        logic [OCC_W-1:0]           occupancy;
    } deq_out_t;

endpackage

>>> src/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/deque_with_value_delete_unit.sv
// Bounded double-ended list of signed 32-bit words held in a circular RAM of
// LIST_DEPTH entries. One item is taken at a time; s_ready is high only while
// the sequencer is idle. Delete by value scans from the front one entry per
// cycle and then closes the gap one entry per cycle. A dump emits one result
// per cycle while m_ready does not stall the output. The single RAM read port,
// stepped once a cycle by the sequencer, sets this pace.
module deque_with_value_delete_unit import deq_pkg::*; #(
    parameter int LIST_DEPTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_out_t m_item
);

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = CW + 1;

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0] opnd_reg, opnd_next;
    logic [IW-1:0]             front_reg, front_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             off_reg, off_next;
    logic [CW-1:0]             n_reg, n_next;
    logic [IW-1:0]             slot_reg;
    logic [IW-1:0]             hole_reg, hole_next;
    logic                      m_valid_reg, m_valid_next;
    deq_out_t                  m_item_reg, m_item_next;

    logic                      out_free;
    logic                      emit;
    deq_out_t                  res;
    logic                      ram_we;
    logic [IW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [IW-1:0]             ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic [31:0]               count_wide;

    function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(LIST_DEPTH)) begin
            sum = sum - SW'(LIST_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_item     = m_item_reg;
    assign count_wide = 32'(count_reg);

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_item.command)
                        CMD_POP_FRONT, CMD_POP_BACK: state_next = S_POP;
                        CMD_DELETE:                  state_next = S_SCAN;
                        CMD_DUMP_ALL, CMD_DUMP_FIRST: state_next = S_DUMP;
                        default:                     state_next = S_SINGLE;
                    endcase
                end
            end
            S_SINGLE, S_POP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (off_reg >= count_reg) begin
                    if (out_free) begin
                        state_next = S_IDLE;
                    end
                end else if (ram_rdata == opnd_reg) begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (off_reg >= count_reg && out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free && (n_reg == '0 || (off_reg + CW'(1)) == n_reg)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next     = cmd_reg;
        opnd_next    = opnd_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        off_next     = off_reg;
        n_next       = n_reg;
        hole_next    = hole_reg;
        ram_we       = 1'b0;
        ram_waddr    = hole_reg;
        ram_wdata    = ram_rdata;
        emit         = 1'b0;
        res          = '0;
        res.last_of_run = 1'b1;
        res.status   = ST_OK;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_item.command;
                    opnd_next = s_item.operand;
                    off_next  = '0;
                    if (s_item.command == CMD_POP_BACK && count_reg != '0) begin
                        off_next = count_reg - CW'(1);
                    end
                    n_next = count_reg;
                    if (s_item.command == CMD_DUMP_FIRST) begin
                        if (s_item.operand[VALUE_W-1] || s_item.operand == '0) begin
                            n_next = '0;
                        end else if (32'(s_item.operand) < count_wide) begin
                            n_next = s_item.operand[CW-1:0];
                        end
                    end
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (cmd_reg == CMD_CLEAR) begin
                        front_next = '0;
                        count_next = '0;
                    end else if (count_reg == CW'(LIST_DEPTH)) begin
                        res.status = ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = opnd_reg;
                        if (cmd_reg == CMD_PUSH_FRONT) begin
                            front_next = (front_reg == '0) ? IW'(LIST_DEPTH - 1)
                                                           : front_reg - IW'(1);
                            ram_waddr  = front_next;
                        end else begin
                            ram_waddr = wrap_idx(front_reg, count_reg);
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (count_reg == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.item_value = ram_rdata;
                        res.item_valid = 1'b1;
                        if (cmd_reg == CMD_POP_FRONT) begin
                            front_next = wrap_idx(front_reg, CW'(1));
                        end
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (off_reg >= count_reg) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        res.status = ST_EMPTY;
                    end
                end else begin
                    if (ram_rdata == opnd_reg) begin
                        hole_next = slot_reg;
                    end
                    off_next = off_reg + CW'(1);
                end
            end
            S_SHIFT: begin
                if (off_reg >= count_reg) begin
                    if (out_free) begin
                        emit           = 1'b1;
                        res.item_value = opnd_reg;
                        res.item_valid = 1'b1;
                        count_next     = count_reg - CW'(1);
                    end
                end else begin
                    // move the entry one place toward the front
                    ram_we    = 1'b1;
                    hole_next = slot_reg;
                    off_next  = off_reg + CW'(1);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (n_reg == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.item_value  = ram_rdata;
                        res.item_valid  = 1'b1;
                        res.last_of_run = ((off_reg + CW'(1)) == n_reg);
                        off_next        = off_reg + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        res.occupancy = OCC_W'(count_next);
        if (emit) begin
            m_valid_next = 1'b1;
            m_item_next  = res;
        end
        ram_raddr = wrap_idx(front_next, off_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        opnd_reg   <= opnd_next;
        off_reg    <= off_next;
        n_reg      <= n_next;
        slot_reg   <= ram_raddr;
        hole_reg   <= hole_next;
        m_item_reg <= m_item_next;
    end

endmodule

>>> src/deq_checker.sv
module deq_checker import deq_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input deq_in_t  s_item,
    input logic     m_valid,
    input logic     m_ready,
    input deq_out_t m_item
);

    // stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // no entry means zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.item_valid |-> m_item.item_value == '0)
        else $error("value without valid entry");

    // error results are single and empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != ST_OK |-> m_item.last_of_run && !m_item.item_valid)
        else $error("error result malformed");

endmodule

bind deque_with_value_delete_unit deq_checker u_deq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

>>> test/tb_deque_with_value_delete_unit.sv
`timescale 1ns / 1ps

module tb_deque_with_value_delete_unit;
    import deq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    deq_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    deq_out_t m_item;

    deq_in_t  cmd_queue[$];
    deq_out_t awaited_items[$];

    logic signed [VALUE_W-1:0] shadow_store [DEPTH];
    int shadow_front = 0;
    int shadow_count = 0;
    logic signed [VALUE_W-1:0] value_pool [6];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic in_fire        = 1'b0;
    int   mismatches     = 0;
    int   cycle_count    = 0;

    deque_with_value_delete_unit #(
        .LIST_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic deq_out_t result_of(logic signed [VALUE_W-1:0] value, logic valid,
                                           logic last, status_t st);
        deq_out_t r;
        r.item_value  = value;
        r.item_valid  = valid;
        r.last_of_run = last;
        r.status      = st;
        r.occupancy   = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic int slot_at(int offset);
        return (shadow_front + offset) % DEPTH;
    endfunction

    function automatic void deque_apply(deq_in_t it);
        logic signed [VALUE_W-1:0] opnd;
        logic signed [VALUE_W-1:0] taken;
        int hit;
        int n;
        int k;
        opnd = it.operand;
        case (it.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    awaited_items.push_back(result_of('0, 1'b0, 1'b1, ST_FULL));
                end else begin
                    if (it.command == CMD_PUSH_FRONT) begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_front] = opnd;
                    end else begin
                        shadow_store[slot_at(shadow_count)] = opnd;
                    end
                    shadow_count++;
                    awaited_items.push_back(result_of('0, 1'b0, 1'b1, ST_OK));
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    awaited_items.push_back(result_of('0, 1'b0, 1'b1, ST_EMPTY));
                end else begin
                    if (it.command == CMD_POP_FRONT) begin
                        taken = shadow_store[shadow_front];
                        shadow_front = slot_at(1);
                    end else begin
                        taken = shadow_store[slot_at(shadow_count - 1)];
                    end
                    shadow_count--;
                    awaited_items.push_back(result_of(taken, 1'b1, 1'b1, ST_OK));
                end
            end
            CMD_CLEAR: begin
                shadow_front = 0;
                shadow_count = 0;
                awaited_items.push_back(result_of('0, 1'b0, 1'b1, ST_OK));
            end
            CMD_DELETE: begin
                hit = -1;
                for (k = 0; k < shadow_count; k++) begin
                    if (hit < 0 && shadow_store[slot_at(k)] == opnd) hit = k;
                end
                if (hit < 0) begin
                    awaited_items.push_back(result_of('0, 1'b0, 1'b1, ST_EMPTY));
                end else begin
                    for (k = hit; k + 1 < shadow_count; k++) begin
                        shadow_store[slot_at(k)] = shadow_store[slot_at(k + 1)];
                    end
                    shadow_count--;
                    awaited_items.push_back(result_of(opnd, 1'b1, 1'b1, ST_OK));
                end
            end
            default: begin
                n = shadow_count;
                if (it.command == CMD_DUMP_FIRST) begin
                    if (opnd <= 0) n = 0;
                    else if (opnd < n) n = opnd;
                end
                if (n == 0) begin
                    awaited_items.push_back(result_of('0, 1'b0, 1'b1, ST_EMPTY));
                end else begin
                    for (k = 0; k < n; k++) begin
                        awaited_items.push_back(result_of(shadow_store[slot_at(k)], 1'b1,
                                                          k + 1 == n, ST_OK));
                    end
                end
            end
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    function automatic void add_cmd(cmd_t c, logic signed [VALUE_W-1:0] v);
        deq_in_t it;
        it.command = c;
        it.operand = v;
        cmd_queue.push_back(it);
    endfunction

    // runs past full so that dropped pushes show up
    function automatic int add_fill();
        int j;
        for (j = 0; j < DEPTH + 2; j++) begin
            add_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value(50));
        end
        return DEPTH + 2;
    endfunction

    function automatic void add_random(int count);
        int made;
        int r;
        int s;
        made = 0;
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 2) begin
                made += add_fill();
            end else begin
                if (r < 20) begin
                    add_cmd(CMD_PUSH_FRONT, pick_value(50));
                end else if (r < 38) begin
                    add_cmd(CMD_PUSH_BACK, pick_value(50));
                end else if (r < 48) begin
                    add_cmd(CMD_POP_FRONT, $urandom);
                end else if (r < 58) begin
                    add_cmd(CMD_POP_BACK, $urandom);
                end else if (r < 61) begin
                    add_cmd(CMD_CLEAR, $urandom);
                end else if (r < 77) begin
                    add_cmd(CMD_DELETE, pick_value(70));
                end else if (r < 88) begin
                    add_cmd(CMD_DUMP_ALL, $urandom);
                end else begin
                    s = $urandom_range(9);
                    if (s < 7) add_cmd(CMD_DUMP_FIRST, $urandom_range(40));
                    else if (s < 8) add_cmd(CMD_DUMP_FIRST, $urandom | 32'h8000_0000);
                    else add_cmd(CMD_DUMP_FIRST, $urandom);
                end
                made++;
            end
        end
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (cmd_queue.size() != 0 || s_valid || awaited_items.size() != 0);
    endtask

    initial begin
        int dummy;
        value_pool[0] = 0;
        value_pool[1] = -1;
        value_pool[2] = 32'sh7FFF_FFFF;
        value_pool[3] = 32'sh8000_0000;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty list cases
        add_cmd(CMD_POP_FRONT, 0);
        add_cmd(CMD_POP_BACK, -1);
        add_cmd(CMD_DELETE, 5);
        add_cmd(CMD_DUMP_ALL, 0);
        add_cmd(CMD_DUMP_FIRST, 3);
        // extremes and a duplicate
        add_cmd(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
        add_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
        add_cmd(CMD_PUSH_BACK, 0);
        add_cmd(CMD_PUSH_FRONT, -1);
        add_cmd(CMD_PUSH_BACK, 0);
        add_cmd(CMD_DUMP_ALL, 0);
        add_cmd(CMD_DUMP_FIRST, 2);
        add_cmd(CMD_DUMP_FIRST, 0);
        add_cmd(CMD_DUMP_FIRST, 32'sh8000_0000);
        add_cmd(CMD_DUMP_FIRST, 100);
        add_cmd(CMD_DELETE, 0);
        add_cmd(CMD_DELETE, 12345);
        add_cmd(CMD_POP_FRONT, 0);
        add_cmd(CMD_POP_BACK, 0);
        add_cmd(CMD_DUMP_ALL, 0);
        add_cmd(CMD_CLEAR, 0);
        add_cmd(CMD_DUMP_ALL, 0);
        add_cmd(CMD_PUSH_FRONT, 5);
        add_cmd(CMD_POP_BACK, 0);

        dummy = add_fill();
        add_random(30);
        wait_drained();

        send_idle_pct  = 79;
        recv_stall_pct = 0;
        add_random(60);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 79;
        add_random(60);
        wait_drained();

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        add_random(70);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_deque_with_value_delete_unit passed");
        end else begin
            $display("tb_deque_with_value_delete_unit failed");
        end
        $finish;
    end

    always @(negedge aclk) begin : drive
        logic    nxt_valid;
        deq_in_t nxt_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_item  = s_item;
            if (s_valid && in_fire) nxt_valid = 1'b0;
            if (!nxt_valid && cmd_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_item  = cmd_queue.pop_front();
            end
            s_valid <= nxt_valid;
            s_item  <= nxt_item;
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watch
        deq_out_t want;
        if (!aresetn) begin
            in_fire = 1'b0;
        end else begin
            in_fire = s_valid && s_ready;
            // results come from items taken at earlier edges
            if (m_valid && m_ready) begin
                if (awaited_items.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value=%0d valid=%0b last=%0b ",
                                 "status=%0d occ=%0d",
                                 m_item.item_value, m_item.item_valid, m_item.last_of_run,
                                 m_item.status, m_item.occupancy);
                end else begin
                    want = awaited_items.pop_front();
                    if (m_item.item_value !== want.item_value ||
                        m_item.item_valid !== want.item_valid ||
                        m_item.last_of_run !== want.last_of_run ||
                        m_item.status !== want.status ||
                        m_item.occupancy !== want.occupancy) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value=%0d valid=%0b last=%0b ",
                                     "status=%0d occ=%0d, got value=%0d valid=%0b ",
                                     "last=%0b status=%0d occ=%0d",
                                     want.item_value, want.item_valid, want.last_of_run,
                                     want.status, want.occupancy,
                                     m_item.item_value, m_item.item_valid,
                                     m_item.last_of_run, m_item.status, m_item.occupancy);
                    end
                end
            end
            if (in_fire) deque_apply(s_item);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_deque_with_value_delete_unit failed");
            $finish;
        end
    end

endmodule
